// ===== rtl/cptit_pkg.sv =====
`timescale 1ns / 1ps

package cptit_pkg;

    // Coordinate width of a stored vertex and of a query point
    localparam int CoordBits = 15;

    // Operation codes
    localparam logic [2:0] OpCreate = 3'd0;
    localparam logic [2:0] OpAppend = 3'd1;
    localparam logic [2:0] OpRemove = 3'd2;
    localparam logic [2:0] OpInside = 3'd3;
    localparam logic [2:0] OpBox    = 3'd4;

    // Status codes
    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StBad  = 2'd1;
    localparam logic [1:0] StFull = 2'd2;

    typedef logic [CoordBits-1:0] t_coord;

    // Command word
    typedef struct packed {
        logic [2:0] op;
        t_coord     x_coord;
        t_coord     y_coord;
        logic [7:0] index;
        logic [8:0] count;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic [1:0] status;
        logic       inside_res;
        t_coord     box_left;
        t_coord     box_top;
        t_coord     box_right;
        t_coord     box_bottom;
    } t_res;

    // One stored vertex
    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vertex;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SHIFT,
        ST_SCAN
    } t_state;

endpackage

// ===== rtl/contour_point_table_with_inside_test_core.sv =====
`timescale 1ns / 1ps

// Contour vertex table with point-inside test and bounding box. A command word
// is taken when i_start is high and o_busy is low; its single result word is
// strobed on o_valid for exactly one cycle and must be captured then, since the
// receiver cannot stall the block. All vertices sit in one single-port-write,
// registered-read memory that is walked one entry per cycle. Append and every
// rejected command answer in the cycle after acceptance. Create of n vertices
// writes one zero per cycle, and Remove at index k moves one vertex per cycle,
// each later vertex one place lower. The inside test adds a multiply stage
// behind the memory read that the bounding box does not wait for. No clearing
// pass runs after reset.
module contour_point_table_with_inside_test_core #(
    parameter int MAX_POINTS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  cptit_pkg::t_cmd i_cmd,
    output logic            o_busy,
    output logic            o_valid,
    output cptit_pkg::t_res o_res
);
    import cptit_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = CoordBits + 1;
    localparam int PW = 2 * DW;

    // Vertex memory
    t_vertex mem [MAX_POINTS];

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ptr,   n_ptr;
    logic [CW-1:0]   r_end,   n_end;
    logic            r_is_box, n_is_box;
    logic            r_out_vld, n_out_vld;
    t_res            r_out,   n_out;

    // Query point and scan pipeline
    t_coord          r_qx, r_qy;
    logic            r_dv;
    logic [CW-1:0]   r_didx;
    t_vertex         r_rdata;
    logic            r_first;
    t_vertex         r_prev;
    t_coord          r_l, r_t, r_r, r_b;
    logic            r_par;
    logic            r_e_vld, r_e_flip, r_e_cross, r_e_neg;
    logic signed [PW-1:0] r_p1, r_p2;

    // Memory port controls
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            w_en;
    logic [AW-1:0]   w_addr;
    t_vertex         w_data;
    logic [CW-1:0]   shift_dst;

    logic            accept;
    logic            scan_done;
    logic            shift_done;

    // Edge evaluation on the word just read
    t_coord          ax, ay, bx, by, hi, lo, topx;
    logic            e_skip, e_flip, e_cross;
    logic signed [DW-1:0] d_ax, d_dy, d_y, d_bx;
    logic signed [PW:0]   cr_sum;
    logic            cr_ok;

    assign accept     = i_start && (r_state == ST_IDLE);
    assign rd_en      = ((r_state == ST_SHIFT) || (r_state == ST_SCAN)) && (r_ptr < r_count);
    assign rd_addr    = r_ptr[AW-1:0];
    assign shift_dst  = r_didx - CW'(1);
    assign scan_done  = !rd_en && !r_dv && !r_e_vld;
    assign shift_done = !rd_en && !r_dv;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.op)
                        OpCreate: begin
                            if (32'(i_cmd.count) <= MAX_POINTS && i_cmd.count != 9'd0) begin
                                n_state = ST_CLEAR;
                            end
                        end
                        OpRemove: begin
                            if (32'(i_cmd.index) < 32'(r_count)) begin
                                n_state = ST_SHIFT;
                            end
                        end
                        OpInside, OpBox: begin
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (r_ptr + CW'(1) == r_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (shift_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs, memory writes and result word
    always_comb begin
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_end     = r_end;
        n_is_box  = r_is_box;
        n_out_vld = 1'b0;
        n_out     = '0;
        w_en      = 1'b0;
        w_addr    = r_ptr[AW-1:0];
        w_data    = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.op)
                        OpCreate: begin
                            if (32'(i_cmd.count) > MAX_POINTS) begin
                                n_out_vld  = 1'b1;
                                n_out.status = StBad;
                            end else if (i_cmd.count == 9'd0) begin
                                n_count    = '0;
                                n_out_vld  = 1'b1;
                                n_out.status = StOk;
                            end else begin
                                n_ptr = '0;
                                n_end = CW'(i_cmd.count);
                            end
                        end
                        OpAppend: begin
                            n_out_vld = 1'b1;
                            if (32'(r_count) >= MAX_POINTS) begin
                                n_out.status = StFull;
                            end else begin
                                w_en         = 1'b1;
                                w_addr       = r_count[AW-1:0];
                                w_data.x     = i_cmd.x_coord;
                                w_data.y     = i_cmd.y_coord;
                                n_count      = r_count + CW'(1);
                                n_out.status = StOk;
                            end
                        end
                        OpRemove: begin
                            if (32'(i_cmd.index) >= 32'(r_count)) begin
                                n_out_vld    = 1'b1;
                                n_out.status = StBad;
                            end else begin
                                n_ptr = CW'(i_cmd.index) + CW'(1);
                            end
                        end
                        OpInside, OpBox: begin
                            if (r_count == '0) begin
                                n_out_vld    = 1'b1;
                                n_out.status = StBad;
                            end else begin
                                n_ptr    = '0;
                                n_is_box = (i_cmd.op == OpBox);
                            end
                        end
                        default: begin
                            n_out_vld    = 1'b1;
                            n_out.status = StBad;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                // write one zero vertex per cycle
                w_en  = 1'b1;
                n_ptr = r_ptr + CW'(1);
                if (r_ptr + CW'(1) == r_end) begin
                    n_count      = r_end;
                    n_out_vld    = 1'b1;
                    n_out.status = StOk;
                end
            end
            ST_SHIFT: begin
                // write each read word one place lower; the read runs two
                // entries ahead of the write, so the two never meet
                if (rd_en) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_dv) begin
                    w_en   = 1'b1;
                    w_addr = shift_dst[AW-1:0];
                    w_data = r_rdata;
                end
                if (shift_done) begin
                    n_count      = r_count - CW'(1);
                    n_out_vld    = 1'b1;
                    n_out.status = StOk;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (scan_done) begin
                    n_out_vld    = 1'b1;
                    n_out.status = StOk;
                    if (r_is_box) begin
                        n_out.box_left   = r_l;
                        n_out.box_top    = r_t;
                        n_out.box_right  = r_r;
                        n_out.box_bottom = r_b;
                    end else begin
                        n_out.inside_res = r_par;
                    end
                end
            end
            default: begin
                n_out_vld = 1'b0;
            end
        endcase
    end

    // Classify edge prev -> current word
    always_comb begin
        ax = r_prev.x;
        ay = r_prev.y;
        bx = r_rdata.x;
        by = r_rdata.y;
        if (ay > by) begin
            hi   = ay;
            lo   = by;
            topx = ax;
        end else begin
            hi   = by;
            lo   = ay;
            topx = bx;
        end
        e_skip  = (ay == by) || (ay > r_qy && by > r_qy) || (ay < r_qy && by < r_qy);
        e_flip  = !e_skip && (hi == r_qy) && (topx > r_qx);
        e_cross = !e_skip && (hi != r_qy) && (lo != r_qy);
        d_ax    = $signed({1'b0, ax}) - $signed({1'b0, r_qx});
        d_dy    = $signed({1'b0, by}) - $signed({1'b0, ay});
        d_y     = $signed({1'b0, r_qy}) - $signed({1'b0, ay});
        d_bx    = $signed({1'b0, bx}) - $signed({1'b0, ax});
    end

    // Sum the two products and take the sign of dy into account
    always_comb begin
        cr_sum = {r_p1[PW-1], r_p1} + {r_p2[PW-1], r_p2};
        if (r_e_neg) begin
            cr_ok = (cr_sum <= 0);
        end else begin
            cr_ok = (cr_sum >= 0);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_end     <= '0;
            r_is_box  <= 1'b0;
            r_out_vld <= 1'b0;
            r_dv      <= 1'b0;
            r_e_vld   <= 1'b0;
            r_first   <= 1'b0;
            r_par     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_end     <= n_end;
            r_is_box  <= n_is_box;
            r_out_vld <= n_out_vld;
            r_dv      <= rd_en;
            r_e_vld   <= (r_state == ST_SCAN) && r_dv && !r_first && !r_is_box;
            if (accept) begin
                r_first <= 1'b1;
                r_par   <= 1'b0;
            end else begin
                if (r_dv) begin
                    r_first <= 1'b0;
                end
                if (r_e_vld) begin
                    r_par <= r_par ^ (r_e_flip | (r_e_cross & cr_ok));
                end
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Hold query point
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qx <= i_cmd.x_coord;
            r_qy <= i_cmd.y_coord;
        end
    end

    // Memory write port and registered read
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        r_didx <= r_ptr;
    end

    // Track previous vertex, bounding box and edge products
    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            r_prev <= r_rdata;
            if (r_first) begin
                r_l <= r_rdata.x;
                r_r <= r_rdata.x;
                r_t <= r_rdata.y;
                r_b <= r_rdata.y;
            end else begin
                if (r_rdata.x < r_l) r_l <= r_rdata.x;
                if (r_rdata.x > r_r) r_r <= r_rdata.x;
                if (r_rdata.y < r_t) r_t <= r_rdata.y;
                if (r_rdata.y > r_b) r_b <= r_rdata.y;
            end
        end
        r_e_flip  <= e_flip;
        r_e_cross <= e_cross;
        r_e_neg   <= d_dy[DW-1];
        r_p1      <= d_ax * d_dy;
        r_p2      <= d_y * d_bx;
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

`ifndef ASSERT_OFF
    // Count never runs past the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("vertex count above table size");

    // Unknown op is rejected in the next cycle
    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd.op != OpCreate && i_cmd.op != OpAppend &&
         i_cmd.op != OpRemove && i_cmd.op != OpInside && i_cmd.op != OpBox)
        |=> (o_valid && o_res.status == StBad))
        else $error("unknown op not rejected");

    // A failing status carries an all-zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status != StOk) |->
        (o_res.inside_res == 1'b0 && o_res.box_left == '0 && o_res.box_top == '0 &&
         o_res.box_right == '0 && o_res.box_bottom == '0))
        else $error("payload set on failing status");

    // Edge stage runs only within an inside scan
    a_edge_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_vld |-> (r_state == ST_SCAN && !r_is_box))
        else $error("edge stage active outside inside scan");
`endif

endmodule
